// ===== rtl/bfsp_pkg.sv =====
// Shared types and constants of the shortest path unit.
// No dependencies; used by the interfaces, the cell and the top level.
package bfsp_pkg;

	localparam int unsigned VW = 7;
	localparam int unsigned UW = 6;
	localparam int unsigned WW = 16;
	localparam int unsigned DW = 32;

	localparam logic [VW-1:0] REG_VERTEX_COUNT = 7'd0;
	localparam logic [VW-1:0] REG_SOURCE_VERTEX = 7'd1;

	typedef struct packed {
		logic                 vld;
		logic                 apply;
		logic [UW-1:0]        u;
		logic signed [DW-1:0] du;
		logic                 ku;
	} tok_t;

	typedef struct packed {
		logic                 wr_en;
		logic [UW-1:0]        a;
		logic [UW-1:0]        b;
		logic signed [WW-1:0] w;
		logic                 clr;
		logic [UW-1:0]        clr_addr;
		logic                 init;
		logic [UW-1:0]        src;
		logic [VW-1:0]        nv;
	} bus_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_GATHER,
		ST_WAIT_G,
		ST_APPLY,
		ST_WAIT_A,
		ST_OUT,
		ST_WAIT_O,
		ST_HOLD
	} st_t;

endpackage

// ===== rtl/bfsp_if.sv =====
// Handshake channels of the shortest path unit: edge, result and config words.
// Depends on bfsp_pkg for field widths.
interface bfsp_edge_if;
	logic                                   valid;
	logic                                   ready;
	logic [bfsp_pkg::VW-1:0]                endpoint_a;
	logic [bfsp_pkg::VW-1:0]                endpoint_b;
	logic signed [bfsp_pkg::WW-1:0]         weight;
	logic                                   last_edge;
	modport source (output valid, endpoint_a, endpoint_b, weight, last_edge, input ready);
	modport sink (input valid, endpoint_a, endpoint_b, weight, last_edge, output ready);
endinterface

interface bfsp_result_if;
	logic                                   valid;
	logic                                   ready;
	logic [bfsp_pkg::VW-1:0]                vertex;
	logic signed [bfsp_pkg::DW-1:0]         distance;
	logic                                   reachable;
	logic                                   last;
	modport source (output valid, vertex, distance, reachable, last, input ready);
	modport sink (input valid, vertex, distance, reachable, last, output ready);
endinterface

interface bfsp_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [bfsp_pkg::VW-1:0]                index;
	logic [bfsp_pkg::VW-1:0]                data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bfsp_cell.sv =====
// One vertex cell: its column of the adjacency matrix, its distance and known bit.
// Depends on bfsp_pkg; passes a row token on to the next cell through its registers tok_s1 and tok_q.
module bfsp_cell #(
	parameter int unsigned MAX_VERTICES = 32,
	parameter int unsigned IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bfsp_pkg::bus_t  bus,
	input  bfsp_pkg::tok_t  tok_in,
	output bfsp_pkg::tok_t  tok_out
);
	localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam logic [bfsp_pkg::UW-1:0] ME = bfsp_pkg::UW'(IDX);

	logic signed [bfsp_pkg::WW-1:0] mem [MAX_VERTICES];
	logic signed [bfsp_pkg::WW-1:0] w_s1;
	bfsp_pkg::tok_t                 tok_s1;
	bfsp_pkg::tok_t                 tok_q;
	bfsp_pkg::tok_t                 tok_d;
	logic signed [bfsp_pkg::DW-1:0] d_q;
	logic                           k_q;
	logic signed [bfsp_pkg::DW:0]   sum;
	logic signed [bfsp_pkg::DW-1:0] cand;
	logic                           active;
	logic                           upd;

	always_ff @(posedge clk) begin
		if (bus.clr) begin
			mem[bus.clr_addr[AW-1:0]] <= '0;
		end else if (bus.wr_en) begin
			if (bus.b == ME) begin
				mem[bus.a[AW-1:0]] <= bus.w;
			end else if (bus.a == ME) begin
				mem[bus.b[AW-1:0]] <= bus.w;
			end
		end
		w_s1 <= mem[tok_in.u[AW-1:0]];
	end

	assign active = (bfsp_pkg::VW'(IDX) < bus.nv);

	always_comb begin
		sum = {tok_s1.du[bfsp_pkg::DW-1], tok_s1.du}
			+ {{(bfsp_pkg::DW+1-bfsp_pkg::WW){w_s1[bfsp_pkg::WW-1]}}, w_s1};
		if (sum[bfsp_pkg::DW] != sum[bfsp_pkg::DW-1]) begin
			cand = sum[bfsp_pkg::DW] ? {1'b1, {(bfsp_pkg::DW-1){1'b0}}}
				: {1'b0, {(bfsp_pkg::DW-1){1'b1}}};
		end else begin
			cand = sum[bfsp_pkg::DW-1:0];
		end
		upd = tok_s1.vld && tok_s1.apply && tok_s1.ku && (w_s1 != '0) && active
			&& (!k_q || (d_q >= cand));
		tok_d = tok_s1;
		if (tok_s1.vld && (tok_s1.u == ME)) begin
			if (!tok_s1.apply) begin
				tok_d.du = d_q;
				tok_d.ku = k_q;
			end else if (upd) begin
				tok_d.du = cand;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_q  <= '0;
			k_q    <= 1'b0;
		end else begin
			tok_s1 <= tok_in;
			tok_q  <= tok_d;
			if (bus.init) begin
				k_q <= (bus.src == ME);
			end else if (upd) begin
				k_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bus.init) begin
			d_q <= '0;
		end else if (upd) begin
			d_q <= cand;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/bellman_ford_shortest_paths_unit.sv =====
// Top level of the shortest path unit: sequencer over a chain of vertex cells.
// Depends on bfsp_pkg, the channel interfaces and bfsp_cell.
//
// channel  dir  word
// edge     in   endpoint_a, endpoint_b, weight, last_edge
// result   out  vertex, distance, reachable, last
// cfg      in   index, data
//
// Edge words are taken back to back while ready; ready is high only while no run is active.
// In a run one row token at a time walks the chain twice (fetch, then relax) for each row
// of each pass, plus a fetch walk per result. After reset, after each run and after a last
// edge with an invalid source, a clearing pass over every matrix address holds ready low.
// A result waits in its output register until taken; cfg is always ready.
module bellman_ford_shortest_paths_unit #(
	parameter int unsigned MAX_VERTICES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	bfsp_edge_if.sink   edge_ch,
	bfsp_result_if.source result,
	bfsp_cfg_if.sink    cfg
);
	localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);
	localparam logic [bfsp_pkg::VW-1:0] MAXV = bfsp_pkg::VW'(MAX_VERTICES);

	bfsp_pkg::st_t state_q, state_d;
	bfsp_pkg::tok_t toks [MAX_VERTICES+1];
	bfsp_pkg::tok_t launch_q;
	bfsp_pkg::bus_t bus;
	logic [AW-1:0] clr_q, row_q, pass_q, outv_q;
	logic [bfsp_pkg::VW-1:0] vc_q, src_q, nv;
	logic [AW-1:0] nvm1, srcm1;
	logic src_ok, edge_ok, acc, exit_vld;
	logic signed [bfsp_pkg::DW-1:0] du_q, dist_q;
	logic ku_q, reach_q, last_q, ov_q;
	logic [bfsp_pkg::VW-1:0] vtx_q;

	assign nv     = (vc_q > MAXV) ? MAXV : vc_q;
	assign nvm1   = AW'(nv - 7'd1);
	assign srcm1  = AW'(src_q - 7'd1);
	assign src_ok = (src_q != '0) && (src_q <= nv);
	assign edge_ok = (edge_ch.endpoint_a != '0) && (edge_ch.endpoint_a <= MAXV)
		&& (edge_ch.endpoint_b != '0) && (edge_ch.endpoint_b <= MAXV);
	assign edge_ch.ready = (state_q == bfsp_pkg::ST_IDLE);
	assign acc = edge_ch.valid && edge_ch.ready;
	assign exit_vld = toks[MAX_VERTICES].vld;
	assign cfg.ready = 1'b1;

	always_comb begin
		bus.wr_en    = acc && edge_ok;
		bus.a        = bfsp_pkg::UW'(edge_ch.endpoint_a - 7'd1);
		bus.b        = bfsp_pkg::UW'(edge_ch.endpoint_b - 7'd1);
		bus.w        = edge_ch.weight;
		bus.clr      = (state_q == bfsp_pkg::ST_CLEAR);
		bus.clr_addr = bfsp_pkg::UW'(clr_q);
		bus.init     = (state_q == bfsp_pkg::ST_INIT);
		bus.src      = bfsp_pkg::UW'(srcm1);
		bus.nv       = nv;
	end

	assign toks[0] = launch_q;

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		bfsp_cell #(
			.MAX_VERTICES(MAX_VERTICES),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.bus(bus),
			.tok_in(toks[i]),
			.tok_out(toks[i+1])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfsp_pkg::ST_CLEAR: if (clr_q == LAST_ADDR) state_d = bfsp_pkg::ST_IDLE;
			bfsp_pkg::ST_IDLE: begin
				if (acc && edge_ch.last_edge) begin
					state_d = src_ok ? bfsp_pkg::ST_INIT : bfsp_pkg::ST_CLEAR;
				end
			end
			bfsp_pkg::ST_INIT: state_d = bfsp_pkg::ST_GATHER;
			bfsp_pkg::ST_GATHER: state_d = bfsp_pkg::ST_WAIT_G;
			bfsp_pkg::ST_WAIT_G: if (exit_vld) state_d = bfsp_pkg::ST_APPLY;
			bfsp_pkg::ST_APPLY: state_d = bfsp_pkg::ST_WAIT_A;
			bfsp_pkg::ST_WAIT_A: begin
				if (exit_vld) begin
					state_d = (row_q == nvm1 && pass_q == nvm1) ? bfsp_pkg::ST_OUT
						: bfsp_pkg::ST_GATHER;
				end
			end
			bfsp_pkg::ST_OUT: begin
				if (outv_q != srcm1) state_d = bfsp_pkg::ST_WAIT_O;
				else if (outv_q == nvm1) state_d = bfsp_pkg::ST_CLEAR;
			end
			bfsp_pkg::ST_WAIT_O: if (exit_vld) state_d = bfsp_pkg::ST_HOLD;
			bfsp_pkg::ST_HOLD: begin
				if (result.ready) state_d = last_q ? bfsp_pkg::ST_CLEAR : bfsp_pkg::ST_OUT;
			end
			default: state_d = bfsp_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bfsp_pkg::ST_CLEAR;
			clr_q    <= '0;
			row_q    <= '0;
			pass_q   <= '0;
			outv_q   <= '0;
			launch_q <= '0;
			ov_q     <= 1'b0;
			vc_q     <= 7'd1;
			src_q    <= 7'd1;
		end else begin
			state_q      <= state_d;
			launch_q.vld <= (state_q == bfsp_pkg::ST_GATHER) || (state_q == bfsp_pkg::ST_APPLY)
				|| (state_q == bfsp_pkg::ST_OUT && outv_q != srcm1);
			launch_q.apply <= (state_q == bfsp_pkg::ST_APPLY);
			launch_q.u     <= bfsp_pkg::UW'((state_q == bfsp_pkg::ST_OUT) ? outv_q : row_q);
			launch_q.du    <= du_q;
			launch_q.ku    <= ku_q;
			if (cfg.valid) begin
				if (cfg.index == bfsp_pkg::REG_VERTEX_COUNT) vc_q <= cfg.data;
				else if (cfg.index == bfsp_pkg::REG_SOURCE_VERTEX) src_q <= cfg.data;
			end
			case (state_q)
				bfsp_pkg::ST_CLEAR: clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + 1'b1;
				bfsp_pkg::ST_INIT: begin
					row_q  <= '0;
					pass_q <= '0;
					outv_q <= '0;
				end
				bfsp_pkg::ST_WAIT_A: begin
					if (exit_vld) begin
						if (row_q == nvm1) begin
							row_q  <= '0;
							pass_q <= pass_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				bfsp_pkg::ST_OUT: if (outv_q == srcm1 && outv_q != nvm1) outv_q <= outv_q + 1'b1;
				bfsp_pkg::ST_WAIT_O: if (exit_vld) ov_q <= 1'b1;
				bfsp_pkg::ST_HOLD: begin
					if (result.ready) begin
						ov_q   <= 1'b0;
						outv_q <= outv_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bfsp_pkg::ST_WAIT_G && exit_vld) begin
			du_q <= toks[MAX_VERTICES].du;
			ku_q <= toks[MAX_VERTICES].ku;
		end
		if (state_q == bfsp_pkg::ST_WAIT_O && exit_vld) begin
			dist_q  <= toks[MAX_VERTICES].ku ? toks[MAX_VERTICES].du : '0;
			reach_q <= toks[MAX_VERTICES].ku;
			vtx_q   <= bfsp_pkg::VW'(outv_q) + 7'd1;
			last_q  <= (outv_q == nvm1) || ((outv_q + 1'b1) == nvm1 && srcm1 == nvm1);
		end
	end

	assign result.valid     = ov_q;
	assign result.vertex    = vtx_q;
	assign result.distance  = dist_q;
	assign result.reachable = reach_q;
	assign result.last      = last_q;

	a_result_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> state_q == bfsp_pkg::ST_HOLD)
		else $error("result word outside hold state");

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		edge_ch.ready |-> !launch_q.vld && !exit_vld)
		else $error("token in chain while taking edges");

	a_apply_exit_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfsp_pkg::ST_WAIT_A && exit_vld) |=> state_q != bfsp_pkg::ST_WAIT_A)
		else $error("relax walk finished without advancing");

endmodule

// ===== tb/bfsp_scoreboard.sv =====
// Scoreboard for the shortest path unit: predicts distances from loaded edges.
// Depends on bfsp_pkg; used by the testbench top.
package bfsp_tb_pkg;

	typedef struct {
		logic [bfsp_pkg::VW-1:0] vertex;
		logic signed [bfsp_pkg::DW-1:0] distance;
		logic reachable;
		logic last;
	} dist_word_t;

	class bfsp_scoreboard;
		localparam int NMAX = 32;
		logic signed [bfsp_pkg::WW-1:0] adj [NMAX][NMAX];
		logic [bfsp_pkg::VW-1:0] vertex_count;
		logic [bfsp_pkg::VW-1:0] source_vertex;
		dist_word_t pending_dists[$];
		int errors;
		int results_seen;
		int runs;

		function new();
			foreach (adj[i, j]) adj[i][j] = '0;
			vertex_count = 1;
			source_vertex = 1;
			errors = 0;
			results_seen = 0;
			runs = 0;
		endfunction

		function void write_reg(logic [bfsp_pkg::VW-1:0] idx, logic [bfsp_pkg::VW-1:0] val);
			if (idx == bfsp_pkg::REG_VERTEX_COUNT) vertex_count = val;
			else if (idx == bfsp_pkg::REG_SOURCE_VERTEX) source_vertex = val;
		endfunction

		function logic signed [bfsp_pkg::DW-1:0] sat_add(logic signed [bfsp_pkg::DW-1:0] d,
				logic signed [bfsp_pkg::WW-1:0] w);
			longint s;
			s = longint'(d) + longint'(w);
			if (s > 64'sd2147483647) return 32'sh7fffffff;
			if (s < -64'sd2147483648) return 32'sh80000000;
			return s[bfsp_pkg::DW-1:0];
		endfunction

		function void note_edge(logic [bfsp_pkg::VW-1:0] a, logic [bfsp_pkg::VW-1:0] b,
				logic signed [bfsp_pkg::WW-1:0] w, logic fin);
			int nv, cnt;
			logic signed [bfsp_pkg::DW-1:0] dval [NMAX];
			logic known [NMAX];
			logic signed [bfsp_pkg::DW-1:0] cand;
			dist_word_t r;
			if (a >= 1 && a <= NMAX && b >= 1 && b <= NMAX) begin
				adj[a-1][b-1] = w;
				adj[b-1][a-1] = w;
			end
			if (!fin) return;
			runs++;
			nv = (vertex_count > NMAX) ? NMAX : vertex_count;
			if (source_vertex >= 1 && source_vertex <= nv) begin
				for (int i = 0; i < NMAX; i++) begin
					dval[i] = '0;
					known[i] = 1'b0;
				end
				known[source_vertex-1] = 1'b1;
				for (int p = 0; p < nv; p++)
					for (int u = 0; u < nv; u++)
						for (int v = 0; v < nv; v++) begin
							if (adj[u][v] == 0 || !known[u]) continue;
							cand = sat_add(dval[u], adj[u][v]);
							if (!known[v] || dval[v] >= cand) begin
								dval[v] = cand;
								known[v] = 1'b1;
							end
						end
				cnt = 0;
				for (int v = 1; v <= nv; v++) begin
					if (v == source_vertex) continue;
					r.vertex = bfsp_pkg::VW'(v);
					r.distance = known[v-1] ? dval[v-1] : '0;
					r.reachable = known[v-1];
					r.last = 1'b0;
					pending_dists = {pending_dists, r};
					cnt++;
				end
				if (cnt > 0) pending_dists[$].last = 1'b1;
			end
			foreach (adj[i, j]) adj[i][j] = '0;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(dist_word_t got);
			dist_word_t exp;
			results_seen++;
			if (pending_dists.size() == 0) begin
				report($sformatf("unexpected word vertex=%0d", got.vertex));
				return;
			end
			exp = pending_dists.pop_front();
			if (got.vertex !== exp.vertex)
				report($sformatf("vertex got %0d exp %0d", got.vertex, exp.vertex));
			if (got.distance !== exp.distance)
				report($sformatf("vertex %0d distance got %0d exp %0d", exp.vertex,
					got.distance, exp.distance));
			if (got.reachable !== exp.reachable)
				report($sformatf("vertex %0d reachable got %0b exp %0b", exp.vertex,
					got.reachable, exp.reachable));
			if (got.last !== exp.last)
				report($sformatf("vertex %0d last got %0b exp %0b", exp.vertex,
					got.last, exp.last));
		endtask
	endclass
endpackage

// ===== tb/tb_bellman_ford_shortest_paths_unit.sv =====
// Testbench top of the shortest path unit: drives edges and config, checks results.
// Depends on bfsp_pkg, bfsp_if and the scoreboard package in bfsp_scoreboard.sv.
module tb_bellman_ford_shortest_paths_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int src_idle_pct;
	int snk_idle_pct;
	int edge_words;

	bfsp_edge_if edge_ch ();
	bfsp_result_if result ();
	bfsp_cfg_if cfg ();
	bfsp_tb_pkg::bfsp_scoreboard sb;

	bellman_ford_shortest_paths_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.edge_ch(edge_ch.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		edge_ch.valid = 1'b0;
		edge_ch.endpoint_a = '0;
		edge_ch.endpoint_b = '0;
		edge_ch.weight = '0;
		edge_ch.last_edge = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		result.ready = 1'b0;
	end

	// sink side: random stall, check each accepted word
	always @(posedge clk) begin
		bfsp_tb_pkg::dist_word_t got;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				got.vertex = result.vertex;
				got.distance = result.distance;
				got.reachable = result.reachable;
				got.last = result.last;
				sb.check_result(got);
			end
			result.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic write_cfg(logic [bfsp_pkg::VW-1:0] idx, logic [bfsp_pkg::VW-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
	endtask

	task automatic send_edge(logic [bfsp_pkg::VW-1:0] a, logic [bfsp_pkg::VW-1:0] b,
			logic signed [bfsp_pkg::WW-1:0] w, logic fin);
		if ($urandom_range(99) < src_idle_pct) begin
			edge_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		edge_ch.valid <= 1'b1;
		edge_ch.endpoint_a <= a;
		edge_ch.endpoint_b <= b;
		edge_ch.weight <= w;
		edge_ch.last_edge <= fin;
		do @(posedge clk); while (!edge_ch.ready);
		sb.note_edge(a, b, w, fin);
		edge_words++;
	endtask

	task automatic drain();
		edge_ch.valid <= 1'b0;
		while (sb.pending_dists.size() != 0) @(posedge clk);
		// run with no results may still be busy: wait out its clearing pass
		repeat (200) @(posedge clk);
	endtask

	task automatic configure(logic [bfsp_pkg::VW-1:0] nv, logic [bfsp_pkg::VW-1:0] src);
		drain();
		write_cfg(bfsp_pkg::REG_VERTEX_COUNT, nv);
		write_cfg(bfsp_pkg::REG_SOURCE_VERTEX, src);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [bfsp_pkg::WW-1:0] rand_weight();
		case ($urandom_range(5))
			0: return bfsp_pkg::WW'($urandom_range(65535));
			1: return 16'sh7fff;
			2: return 16'sh8000;
			default: return bfsp_pkg::WW'(int'($urandom_range(40)) - 10);
		endcase
	endfunction

	// one graph: edges mostly within nv, some out of range, last flagged
	task automatic random_graph(int nv, int n);
		logic [bfsp_pkg::VW-1:0] a, b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				a = bfsp_pkg::VW'($urandom_range(127));
				b = bfsp_pkg::VW'($urandom_range(127));
			end else begin
				a = bfsp_pkg::VW'($urandom_range(nv > 1 ? nv : 2, 1));
				b = bfsp_pkg::VW'($urandom_range(nv > 1 ? nv : 2, 1));
			end
			send_edge(a, b, rand_weight(), i == n - 1);
		end
	endtask

	task automatic random_phase(int words);
		int nv, src, n;
		while (words > 0) begin
			nv = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8, 1);
			src = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(nv, 1);
			configure(bfsp_pkg::VW'(nv), bfsp_pkg::VW'(src));
			n = $urandom_range(12, 1);
			random_graph(nv, n);
			words -= n;
		end
	endtask

	initial begin
		sb = new();
		edge_words = 0;
		src_idle_pct = 25;
		snk_idle_pct = 50;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single vertex, no results
		send_edge(7'd1, 7'd1, 16'sd5, 1'b1);
		configure(7'd4, 7'd1);
		send_edge(7'd1, 7'd2, 16'sh7fff, 1'b0);
		send_edge(7'd2, 7'd3, 16'sh7fff, 1'b0);
		send_edge(7'd0, 7'd3, 16'sd9, 1'b0);
		send_edge(7'd127, 7'd64, 16'sd9, 1'b0);
		send_edge(7'd3, 7'd40, 16'sd9, 1'b1);
		configure(7'd3, 7'd2);
		send_edge(7'd1, 7'd2, 16'sh8000, 1'b0);
		send_edge(7'd2, 7'd3, 16'sh8000, 1'b0);
		send_edge(7'd2, 7'd3, 16'sd0, 1'b0);
		send_edge(7'd3, 7'd1, -16'sd7, 1'b1);
		configure(7'd127, 7'd32);
		send_edge(7'd31, 7'd32, 16'sd3, 1'b0);
		send_edge(7'd1, 7'd31, 16'sd1, 1'b0);
		send_edge(7'd32, 7'd32, 16'sd2, 1'b1);
		configure(7'd5, 7'd0);
		send_edge(7'd1, 7'd2, 16'sd1, 1'b1);
		configure(7'd0, 7'd1);
		send_edge(7'd1, 7'd2, 16'sd1, 1'b1);
		configure(7'd5, 7'd6);
		send_edge(7'd1, 7'd2, 16'sd1, 1'b1);
		configure(7'd64, 7'd64);
		send_edge(7'd64, 7'd1, 16'sd1, 1'b1);
		configure(7'd2, 7'd2);
		send_edge(7'd1, 7'd2, 16'sd4, 1'b1);

		random_phase(150);
		src_idle_pct = 50;
		snk_idle_pct = 25;
		random_phase(150);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(150);
		drain();

		$display("Covered %0d edge words over %0d runs, %0d result words checked.",
			edge_words, sb.runs, sb.results_seen);
		if (sb.errors == 0 && sb.pending_dists.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#1s;
		$display("Timeout with %0d results outstanding", sb.pending_dists.size());
		$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/bfsp_pkg.sv
rtl/bfsp_if.sv
rtl/bfsp_cell.sv
rtl/bellman_ford_shortest_paths_unit.sv
tb/bfsp_scoreboard.sv
tb/tb_bellman_ford_shortest_paths_unit.sv
